[sv/atan2sa_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// atan2sa_pkg
// Shared widths, Q0.30 angle constants and the control structs passed between
// the angle unit, its series sequencer and the shared divider.
// ============================================================================
package atan2sa_pkg;

   // Coordinate and magnitude widths
   localparam int COORD_W = 16;
   localparam int MAG_W   = 16;

   // Q0.30 fractions and series sum
   localparam int FRAC_W = 30;
   localparam int SUM_W  = 32;

   // Shared divider: 60-bit dividend, 31-bit divisor, 30-bit quotient
   localparam int DIV_NUM_W   = 60;
   localparam int DIV_DEN_W   = 31;
   localparam int DIV_STEPS   = FRAC_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   // Shared multiplier
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;

   // Series term limit and term counter width
   localparam int MAX_TERMS = 48;
   localparam int TERM_W    = $clog2(MAX_TERMS + 1);
   localparam int KW        = TERM_W + 2;

   // Stop threshold, about 1e-7 in Q0.30
   localparam logic [FRAC_W-1:0] STOP_Q30 = 30'd107;
   localparam logic [SUM_W-1:0]  ONE_Q30  = 32'd1073741824;
   localparam logic [DIV_DEN_W-1:0] DIV_BY_3 = 31'd3;

   // Signed Q0.30 angles
   localparam int ANG_W = 34;
   localparam logic signed [ANG_W-1:0] PI_Q30          = 34'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30     = 34'sd1686629713;
   localparam logic signed [ANG_W-1:0] QUARTER_PI_Q30  = 34'sd843314856;
   localparam logic signed [ANG_W-1:0] THREE_QTR_PI_Q30 = 34'sd2529944569;

   // Output angle, signed Q3.13
   localparam int OUT_W = 16;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] s;
      logic [MAG_W-1:0] b;
   } ser_req_type;

   typedef struct packed {
      logic              done;
      logic [FRAC_W-1:0] t;
   } ser_rsp_type;

endpackage

[sv/atan2sa_div.sv]
`timescale 1ns / 1ps
// ============================================================================
// atan2sa_div
// Restoring divider, one quotient bit per cycle. The dividend's upper half
// must be below the divisor so the quotient fits in 30 bits.
// ============================================================================
module atan2sa_div (
   input  logic                     clock,
   input  logic                     reset,
   input  atan2sa_pkg::div_req_type div_req,
   output atan2sa_pkg::div_rsp_type div_rsp
);

   logic                                busy_ff;
   logic                                done_ff;
   logic [atan2sa_pkg::DIV_CNT_W-1:0]   cnt_ff;
   logic [atan2sa_pkg::DIV_DEN_W-1:0]   rem_ff;
   logic [atan2sa_pkg::DIV_DEN_W-1:0]   den_ff;
   logic [atan2sa_pkg::FRAC_W-1:0]      lo_ff;

   logic [atan2sa_pkg::DIV_DEN_W:0]     rem_sh;
   logic                                fits;
   logic [atan2sa_pkg::DIV_DEN_W-1:0]   rem_in;

   // Shift in the next dividend bit, then compare and subtract
   always_comb begin
      rem_sh = {rem_ff, lo_ff[atan2sa_pkg::FRAC_W-1]};
      fits   = (rem_sh >= {1'b0, den_ff});
      if (fits) begin
         rem_in = atan2sa_pkg::DIV_DEN_W'(rem_sh - {1'b0, den_ff});
      end else begin
         rem_in = rem_sh[atan2sa_pkg::DIV_DEN_W-1:0];
      end
   end

   // Load on start, step while busy; quotient bits collect in lo_ff
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            rem_ff  <= {1'b0, div_req.num[atan2sa_pkg::DIV_NUM_W-1:atan2sa_pkg::FRAC_W]};
            lo_ff   <= div_req.num[atan2sa_pkg::FRAC_W-1:0];
            den_ff  <= div_req.den;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            lo_ff  <= {lo_ff[atan2sa_pkg::FRAC_W-2:0], fits};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == atan2sa_pkg::DIV_CNT_W'(atan2sa_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = lo_ff;

   // A new division never starts on top of a running one
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider started while busy");

   // The partial remainder stays below the divisor
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < den_ff))
      else $error("divider remainder out of range");

endmodule

[sv/atan2sa_series.sv]
`timescale 1ns / 1ps
// ============================================================================
// atan2sa_series
// Sequencer for atan(s/b), 0 < s < b, by the Euler series in Q0.30. One
// registered multiplier and the shared divider do all products and quotients.
// ============================================================================
module atan2sa_series (
   input  logic                     clock,
   input  logic                     reset,
   input  atan2sa_pkg::ser_req_type ser_req,
   output atan2sa_pkg::ser_rsp_type ser_rsp
);

   typedef enum logic [3:0] {
      S_IDLE, S_BB, S_SS, S_ZGO, S_ZW, S_FW, S_PW0,
      S_TERM, S_MULK, S_PGO, S_PW, S_FIN, S_OUT
   } state_type;

   state_type                              state_ff;
   logic [atan2sa_pkg::MAG_W-1:0]          s_ff;
   logic [atan2sa_pkg::MAG_W-1:0]          b_ff;
   logic [atan2sa_pkg::DIV_DEN_W-1:0]      d_ff;
   logic [atan2sa_pkg::FRAC_W-1:0]         z_ff;
   logic [atan2sa_pkg::FRAC_W-1:0]         f_ff;
   logic [atan2sa_pkg::FRAC_W-1:0]         p_ff;
   logic [atan2sa_pkg::SUM_W-1:0]          sum_ff;
   logic [atan2sa_pkg::TERM_W-1:0]         n_ff;
   logic [atan2sa_pkg::PROD_W-1:0]         prod_ff;
   atan2sa_pkg::div_req_type               div_req_ff;
   atan2sa_pkg::ser_rsp_type               ser_rsp_ff;

   atan2sa_pkg::div_rsp_type               div_rsp;
   logic                                   mul_en;
   logic [atan2sa_pkg::MUL_W-1:0]          mul_a;
   logic [atan2sa_pkg::MUL_W-1:0]          mul_b;
   logic [atan2sa_pkg::DIV_DEN_W-1:0]      d_sum;
   logic [atan2sa_pkg::KW-1:0]             k_mul;
   logic [atan2sa_pkg::KW-1:0]             k_den;

   atan2sa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   // Series factors (2n+2) and (2n+3), and d = b*b + s*s
   assign k_mul = atan2sa_pkg::KW'({n_ff, 1'b0}) + atan2sa_pkg::KW'(2);
   assign k_den = atan2sa_pkg::KW'({n_ff, 1'b1}) + atan2sa_pkg::KW'(2);
   assign d_sum = d_ff + prod_ff[atan2sa_pkg::DIV_DEN_W-1:0];

   // Select multiplier operands for the current step
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         S_BB: begin
            mul_a = atan2sa_pkg::MUL_W'(b_ff);
            mul_b = atan2sa_pkg::MUL_W'(b_ff);
         end
         S_SS: begin
            mul_a = atan2sa_pkg::MUL_W'(s_ff);
            mul_b = atan2sa_pkg::MUL_W'(s_ff);
         end
         S_ZGO: begin
            mul_a = atan2sa_pkg::MUL_W'(s_ff);
            mul_b = atan2sa_pkg::MUL_W'(b_ff);
         end
         S_TERM: begin
            mul_a = atan2sa_pkg::MUL_W'(p_ff);
            mul_b = atan2sa_pkg::MUL_W'(z_ff);
         end
         S_MULK: begin
            mul_a = atan2sa_pkg::MUL_W'(prod_ff[2*atan2sa_pkg::FRAC_W-1:atan2sa_pkg::FRAC_W]);
            mul_b = atan2sa_pkg::MUL_W'(k_mul);
         end
         S_FIN: begin
            mul_a = atan2sa_pkg::MUL_W'(f_ff);
            mul_b = sum_ff;
         end
         default: begin
            mul_en = 1'b0;
         end
      endcase
   end

   // Sequencer: squares, three divisions, then one term per pass
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         div_req_ff.start <= 1'b0;
         ser_rsp_ff.done  <= 1'b0;
      end else begin
         div_req_ff.start <= 1'b0;
         ser_rsp_ff.done  <= 1'b0;
         if (mul_en) begin
            prod_ff <= mul_a * mul_b;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (ser_req.start) begin
                  s_ff     <= ser_req.s;
                  b_ff     <= ser_req.b;
                  state_ff <= S_BB;
               end
            end
            S_BB: begin
               state_ff <= S_SS;
            end
            S_SS: begin
               d_ff     <= prod_ff[atan2sa_pkg::DIV_DEN_W-1:0];
               state_ff <= S_ZGO;
            end
            S_ZGO: begin
               // z = s*s * 2^30 / d
               d_ff       <= d_sum;
               div_req_ff <= '{start: 1'b1,
                              num: {prod_ff[atan2sa_pkg::FRAC_W-1:0],
                                    atan2sa_pkg::FRAC_W'(0)},
                              den: d_sum};
               state_ff   <= S_ZW;
            end
            S_ZW: begin
               // f = s*b * 2^30 / d
               if (div_rsp.done) begin
                  z_ff       <= div_rsp.quot;
                  div_req_ff <= '{start: 1'b1,
                                 num: {prod_ff[atan2sa_pkg::FRAC_W-1:0],
                                       atan2sa_pkg::FRAC_W'(0)},
                                 den: d_ff};
                  state_ff   <= S_FW;
               end
            end
            S_FW: begin
               // first term p = 2z / 3
               if (div_rsp.done) begin
                  f_ff       <= div_rsp.quot;
                  div_req_ff <= '{start: 1'b1,
                                 num: atan2sa_pkg::DIV_NUM_W'({z_ff, 1'b0}),
                                 den: atan2sa_pkg::DIV_BY_3};
                  state_ff   <= S_PW0;
               end
            end
            S_PW0: begin
               if (div_rsp.done) begin
                  p_ff     <= div_rsp.quot;
                  sum_ff   <= atan2sa_pkg::ONE_Q30;
                  n_ff     <= atan2sa_pkg::TERM_W'(1);
                  state_ff <= S_TERM;
               end
            end
            S_TERM: begin
               // accumulate, then stop on a small term or at the term limit
               sum_ff <= sum_ff + atan2sa_pkg::SUM_W'(p_ff);
               if ((p_ff <= atan2sa_pkg::STOP_Q30) ||
                   (n_ff == atan2sa_pkg::TERM_W'(atan2sa_pkg::MAX_TERMS))) begin
                  state_ff <= S_FIN;
               end else begin
                  state_ff <= S_MULK;
               end
            end
            S_MULK: begin
               state_ff <= S_PGO;
            end
            S_PGO: begin
               // next p = ((p*z) >> 30) * (2n+2) / (2n+3)
               div_req_ff <= '{start: 1'b1,
                              num: prod_ff[atan2sa_pkg::DIV_NUM_W-1:0],
                              den: atan2sa_pkg::DIV_DEN_W'(k_den)};
               n_ff       <= n_ff + 1'b1;
               state_ff   <= S_PW;
            end
            S_PW: begin
               if (div_rsp.done) begin
                  p_ff     <= div_rsp.quot;
                  state_ff <= S_TERM;
               end
            end
            S_FIN: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               // t = (f * sum) >> 30
               ser_rsp_ff.t    <= prod_ff[2*atan2sa_pkg::FRAC_W-1:atan2sa_pkg::FRAC_W];
               ser_rsp_ff.done <= 1'b1;
               state_ff        <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign ser_rsp = ser_rsp_ff;

endmodule

[sv/atan2_series_angle_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// atan2_series_angle_unit
// Four-quadrant arctangent of a signed 16-bit vector, result in radians as
// signed Q3.13. Axis and diagonal vectors take fixed angles; all others go
// through the Euler-series sequencer on the smaller/larger magnitude.
// ============================================================================
//
// channel   dir   fields (tdata, lowest bit up)
// req       in    y_coord[15:0], x_coord[31:16]   signed integers
// rsp       out   angle[15:0]                     signed Q3.13
//
// Axis and diagonal vectors skip the series: T_CLASS goes to T_FINISH, which
// loads the fixed angle. Other vectors: one term per pass through the shared
// bit-serial divider and multiplier, at most 48 terms.
// req_tready is high only while no item is in work.
// Reset (synchronous) clears the sequencers and the result valid.
// A stalled result is held in the output register; the next item is taken
// meanwhile but its result waits until that register frees.
// ============================================================================
module atan2_series_angle_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // y_coord[15:0], x_coord[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // angle[15:0]
);

   typedef enum logic [1:0] {
      T_IDLE, T_CLASS, T_RUN, T_FINISH
   } state_type;

   state_type                                state_ff;
   logic signed [atan2sa_pkg::COORD_W-1:0]   y_ff;
   logic signed [atan2sa_pkg::COORD_W-1:0]   x_ff;
   logic [atan2sa_pkg::FRAC_W-1:0]           t_ff;
   logic                                     rsp_tvalid_ff;
   logic [atan2sa_pkg::OUT_W-1:0]            rsp_tdata_ff;
   atan2sa_pkg::ser_req_type                 ser_req_ff;
   atan2sa_pkg::ser_rsp_type                 ser_rsp;

   logic                                     y_zero;
   logic                                     x_zero;
   logic                                     y_pos;
   logic                                     x_pos;
   logic                                     x_neg;
   logic [atan2sa_pkg::MAG_W:0]              ay;
   logic [atan2sa_pkg::MAG_W:0]              ax;
   logic                                     special;
   logic signed [atan2sa_pkg::ANG_W-1:0]     tq;
   logic signed [atan2sa_pkg::ANG_W-1:0]     ang;
   logic [atan2sa_pkg::ANG_W-1:0]            mag;
   logic [atan2sa_pkg::ANG_W-1:0]            mag_rnd;
   logic [atan2sa_pkg::OUT_W-1:0]            mag_q13;
   logic [atan2sa_pkg::OUT_W-1:0]            ang_q13;

   atan2sa_series u_series (
      .clock   (clock),
      .reset   (reset),
      .ser_req (ser_req_ff),
      .ser_rsp (ser_rsp)
   );

   // Signs and magnitudes of the held vector
   always_comb begin
      y_zero = (y_ff == '0);
      x_zero = (x_ff == '0);
      y_pos  = !y_ff[atan2sa_pkg::COORD_W-1] && !y_zero;
      x_pos  = !x_ff[atan2sa_pkg::COORD_W-1] && !x_zero;
      x_neg  = x_ff[atan2sa_pkg::COORD_W-1];
      if (y_ff[atan2sa_pkg::COORD_W-1]) begin
         ay = (atan2sa_pkg::MAG_W + 1)'(0) - {y_ff[atan2sa_pkg::COORD_W-1], y_ff};
      end else begin
         ay = {1'b0, y_ff};
      end
      if (x_neg) begin
         ax = (atan2sa_pkg::MAG_W + 1)'(0) - {x_ff[atan2sa_pkg::COORD_W-1], x_ff};
      end else begin
         ax = {1'b0, x_ff};
      end
      special = y_zero || x_zero || (ay == ax);
   end

   // Map the octant angle t to the full circle, in signed Q0.30
   always_comb begin
      tq = signed'(atan2sa_pkg::ANG_W'(t_ff));
      if (y_zero) begin
         ang = x_neg ? atan2sa_pkg::PI_Q30 : '0;
      end else if (x_zero) begin
         ang = y_pos ? atan2sa_pkg::HALF_PI_Q30 : -atan2sa_pkg::HALF_PI_Q30;
      end else if (ay == ax) begin
         if (y_pos == x_pos) begin
            ang = y_pos ? atan2sa_pkg::QUARTER_PI_Q30 : -atan2sa_pkg::THREE_QTR_PI_Q30;
         end else begin
            ang = x_pos ? -atan2sa_pkg::QUARTER_PI_Q30 : atan2sa_pkg::THREE_QTR_PI_Q30;
         end
      end else if (ay < ax) begin
         if (x_pos) begin
            ang = y_pos ? tq : -tq;
         end else begin
            ang = y_pos ? (atan2sa_pkg::PI_Q30 - tq) : (tq - atan2sa_pkg::PI_Q30);
         end
      end else begin
         if (y_pos) begin
            ang = x_pos ? (atan2sa_pkg::HALF_PI_Q30 - tq)
                        : (atan2sa_pkg::HALF_PI_Q30 + tq);
         end else begin
            ang = x_pos ? (tq - atan2sa_pkg::HALF_PI_Q30)
                        : (-atan2sa_pkg::HALF_PI_Q30 - tq);
         end
      end
   end

   // Round the magnitude to Q3.13, halves away from zero
   always_comb begin
      mag     = ang[atan2sa_pkg::ANG_W-1] ? unsigned'(-ang) : unsigned'(ang);
      mag_rnd = mag + atan2sa_pkg::ANG_W'(65536);
      mag_q13 = mag_rnd[atan2sa_pkg::OUT_W+16:17];
      if (ang[atan2sa_pkg::ANG_W-1]) begin
         ang_q13 = atan2sa_pkg::OUT_W'(0) - mag_q13;
      end else begin
         ang_q13 = mag_q13;
      end
   end

   // Control: take an item, classify, run the series, hand off the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= T_IDLE;
         rsp_tvalid_ff    <= 1'b0;
         ser_req_ff.start <= 1'b0;
      end else begin
         ser_req_ff.start <= 1'b0;
         if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         unique case (state_ff)
            T_IDLE: begin
               if (req_tvalid) begin
                  y_ff     <= signed'(req_tdata[15:0]);
                  x_ff     <= signed'(req_tdata[31:16]);
                  state_ff <= T_CLASS;
               end
            end
            T_CLASS: begin
               if (special) begin
                  state_ff <= T_FINISH;
               end else begin
                  ser_req_ff.start <= 1'b1;
                  if (ay < ax) begin
                     ser_req_ff.s <= ay[atan2sa_pkg::MAG_W-1:0];
                     ser_req_ff.b <= ax[atan2sa_pkg::MAG_W-1:0];
                  end else begin
                     ser_req_ff.s <= ax[atan2sa_pkg::MAG_W-1:0];
                     ser_req_ff.b <= ay[atan2sa_pkg::MAG_W-1:0];
                  end
                  state_ff <= T_RUN;
               end
            end
            T_RUN: begin
               if (ser_rsp.done) begin
                  t_ff     <= ser_rsp.t;
                  state_ff <= T_FINISH;
               end
            end
            T_FINISH: begin
               // load only once the output register is free
               if (!rsp_tvalid_ff || rsp_tready) begin
                  rsp_tdata_ff  <= ang_q13;
                  rsp_tvalid_ff <= 1'b1;
                  state_ff      <= T_IDLE;
               end
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == T_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // One item in work at a time
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("item accepted while another is in work");

   // The series only finishes for an item that was sent to it
   a_series_in_run: assert property (@(posedge clock) disable iff (reset)
      ser_rsp.done |-> (state_ff == T_RUN))
      else $error("series result outside of run state");

endmodule

[tb/tb_atan2_series_angle_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_atan2_series_angle_unit
// Self-checking bench for the four-quadrant arctangent unit. Drives (y, x)
// items with random gaps, stalls the angle stream at random, and checks every
// angle against a bit-true Euler-series predictor. A directed table covers the
// axes, the diagonals, the full-scale corners and each octant first; random
// vectors follow, some of them on the axes and diagonals.
// ============================================================================
module tb_atan2_series_angle_unit;
   import atan2sa_pkg::*;

   localparam int CLK_HALF     = 4;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1300;
   localparam int STALL_LIMIT  = 20000;
   localparam int DRAIN_CYCLES = 16;
   localparam int DIRECTED_LEN = 24;

   // Fixed angles in Q3.13
   localparam logic signed [15:0] ANG_PI       = 16'sd25736;
   localparam logic signed [15:0] ANG_HALF_PI  = 16'sd12868;
   localparam logic signed [15:0] ANG_QTR_PI   = 16'sd6434;
   localparam logic signed [15:0] ANG_3QTR_PI  = 16'sd19302;
   localparam logic signed [15:0] COORD_MIN    = 16'sh8000;
   localparam logic signed [15:0] COORD_MAX    = 16'sh7FFF;

   typedef struct packed {
      logic signed [15:0] y;
      logic signed [15:0] x;
      logic               fixed;   // angle column is valid
      logic signed [15:0] angle;
   } vec_row_t;

   typedef struct packed {
      logic signed [15:0] y;
      logic signed [15:0] x;
      logic signed [15:0] angle;
   } angle_exp_t;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;    // y_coord[15:0], x_coord[31:16]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // angle[15:0]

   angle_exp_t  angle_q[$];
   angle_exp_t  pend_vec   = '0;
   logic        idle_on    = 1'b1;
   int unsigned rsp_wait   = 0;
   int unsigned quiet_cnt  = 0;
   int unsigned errors     = 0;
   vec_row_t    dir_rows [DIRECTED_LEN];

   atan2_series_angle_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Clock
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // atan(s/b) in Q0.30 by the Euler series, for 0 < s < b
   function automatic logic [63:0] series_arctan(input logic [63:0] s, input logic [63:0] b);
      logic [63:0] den;
      logic [63:0] z;
      logic [63:0] f;
      logic [63:0] sum;
      logic [63:0] p;
      logic [63:0] k;
      den = b * b + s * s;
      z   = (s * s << 30) / den;
      f   = (s * b << 30) / den;
      sum = 64'd1 << 30;
      p   = z * 64'd2 / 64'd3;
      for (k = 1; k <= MAX_TERMS; k++) begin
         sum += p;
         if (p <= 64'(STOP_Q30))
            break;
         p = ((p * z) >> 30) * (2 * k + 2) / (2 * k + 3);
      end
      return (f * sum) >> 30;
   endfunction

   // Four-quadrant angle in signed Q0.30
   function automatic logic signed [63:0] vector_angle(input logic signed [15:0] y_in,
                                                       input logic signed [15:0] x_in);
      logic signed [63:0] y;
      logic signed [63:0] x;
      logic signed [63:0] ay;
      logic signed [63:0] ax;
      logic signed [63:0] t;
      logic signed [63:0] pi;
      logic signed [63:0] hpi;
      y   = y_in;
      x   = x_in;
      ay  = (y < 0) ? -y : y;
      ax  = (x < 0) ? -x : x;
      pi  = PI_Q30;
      hpi = HALF_PI_Q30;
      if (y == 0)
         return (x < 0) ? pi : 64'sd0;
      if (x == 0)
         return (y > 0) ? hpi : -hpi;
      if (ay == ax) begin
         if ((y > 0) == (x > 0))
            return (y > 0) ? 64'(QUARTER_PI_Q30) : -64'(THREE_QTR_PI_Q30);
         return (x > 0) ? -64'(QUARTER_PI_Q30) : 64'(THREE_QTR_PI_Q30);
      end
      if (ay < ax) begin
         t = series_arctan(ay, ax);
         if (x > 0)
            return (y > 0) ? t : -t;
         return (y > 0) ? pi - t : t - pi;
      end
      t = series_arctan(ax, ay);
      if (y > 0)
         return (x > 0) ? hpi - t : hpi + t;
      return (x > 0) ? t - hpi : -hpi - t;
   endfunction

   // Round Q0.30 to Q3.13, magnitude to nearest, halves away from zero
   function automatic logic [15:0] round_q13(input logic signed [63:0] v);
      logic [63:0] mag;
      logic [63:0] r;
      mag = (v < 0) ? -v : v;
      r   = (mag + (64'd1 << 16)) >> 17;
      if (v < 0)
         r = -r;
      return r[15:0];
   endfunction

   // Present one vector; return at the edge where it is taken
   task automatic send_vector(input logic signed [15:0] y, input logic signed [15:0] x,
                              input logic signed [15:0] angle);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pend_vec   <= '{y: y, x: x, angle: angle};
      req_tdata  <= {x, y};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Hold off the sender until every angle is back
   task automatic drain_angles();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (angle_q.size() != 0);
   endtask

   // Result side pacing: draw a stall after every taken angle
   always @(posedge clock) begin : rsp_pace
      int unsigned w;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         w = idle_on ? $urandom_range(0, 3) : 0;
         rsp_wait   <= w;
         rsp_tready <= (w == 0);
      end else if (rsp_wait > 0) begin
         rsp_wait   <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Record taken vectors, compare returned angles
   always @(posedge clock) begin : scoreboard
      angle_exp_t e;
      if (!reset) begin
         if (req_tvalid && req_tready)
            angle_q.push_back(pend_vec);
         if (rsp_tvalid && rsp_tready) begin
            if (angle_q.size() == 0) begin
               $display("%0t: unexpected angle %0d with nothing outstanding", $time,
                        $signed(rsp_tdata));
               errors++;
            end else begin
               e = angle_q.pop_front();
               if (rsp_tdata !== e.angle) begin
                  $display("%0t: angle mismatch y=%0d x=%0d: expected %0d, actual %0d",
                           $time, e.y, e.x, e.angle, $signed(rsp_tdata));
                  errors++;
               end
            end
         end
      end
   end

   // Watchdog on cycles with no traffic on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cnt <= 0;
      end else if (quiet_cnt >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, quiet_cnt);
         $display("atan2_series_angle_unit test failed");
         $finish;
      end else begin
         quiet_cnt <= quiet_cnt + 1;
      end
   end

   // Main sequence
   initial begin : stimulus
      logic signed [15:0] y;
      logic signed [15:0] x;
      logic signed [15:0] extremes [7];
      int unsigned        kind;
      int unsigned        mag;

      extremes = '{COORD_MIN, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32766, COORD_MAX};

      // Axes, diagonals and full scale with fixed angles, then every octant
      dir_rows = '{
         '{16'sd0,      16'sd0,      1'b1, 16'sd0},
         '{16'sd0,      16'sd1,      1'b1, 16'sd0},
         '{16'sd0,      -16'sd1,     1'b1, ANG_PI},
         '{16'sd0,      COORD_MAX,   1'b1, 16'sd0},
         '{16'sd0,      COORD_MIN,   1'b1, ANG_PI},
         '{16'sd1,      16'sd0,      1'b1, ANG_HALF_PI},
         '{-16'sd1,     16'sd0,      1'b1, -ANG_HALF_PI},
         '{COORD_MAX,   16'sd0,      1'b1, ANG_HALF_PI},
         '{COORD_MIN,   16'sd0,      1'b1, -ANG_HALF_PI},
         '{16'sd100,    16'sd100,    1'b1, ANG_QTR_PI},
         '{-16'sd100,   -16'sd100,   1'b1, -ANG_3QTR_PI},
         '{16'sd100,    -16'sd100,   1'b1, ANG_3QTR_PI},
         '{-16'sd100,   16'sd100,    1'b1, -ANG_QTR_PI},
         '{COORD_MAX,   COORD_MAX,   1'b1, ANG_QTR_PI},
         '{COORD_MIN,   COORD_MIN,   1'b1, -ANG_3QTR_PI},
         '{16'sd1,      COORD_MAX,   1'b0, 16'sd0},
         '{-16'sd1,     COORD_MIN,   1'b0, 16'sd0},
         '{16'sd12345,  -16'sd30000, 1'b0, 16'sd0},
         '{-16'sd2,     16'sd3,      1'b0, 16'sd0},
         '{COORD_MAX,   COORD_MIN,   1'b0, 16'sd0},
         '{COORD_MIN,   COORD_MAX,   1'b0, 16'sd0},
         '{16'sd30000,  16'sd1,      1'b0, 16'sd0},
         '{16'sd5,      -16'sd4,     1'b0, 16'sd0},
         '{COORD_MIN,   -16'sd1,     1'b0, 16'sd0}
      };

      // Reset
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table
      foreach (dir_rows[i])
         send_vector(dir_rows[i].y, dir_rows[i].x,
                     dir_rows[i].fixed ? dir_rows[i].angle
                                       : round_q13(vector_angle(dir_rows[i].y,
                                                                dir_rows[i].x)));
      drain_angles();

      // Random vectors, with idle and no-idle stretches
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0)
            idle_on <= ($urandom_range(0, 3) != 0);
         if (n == RANDOM_ITEMS / 2)
            drain_angles();
         kind = $urandom_range(0, 9);
         case (kind)
            6: begin
               y = 16'($signed($urandom_range(0, 128)) - 64);
               x = 16'($signed($urandom_range(0, 128)) - 64);
            end
            7: begin
               y = 16'($urandom);
               x = 16'sd0;
               if ($urandom_range(0, 1)) begin
                  x = y;
                  y = 16'sd0;
               end
            end
            8: begin
               // Equal magnitudes; +32768 does not exist, so force negative
               mag = $urandom_range(1, 32768);
               y = $urandom_range(0, 1) || mag == 32768 ? 16'(-mag) : 16'(mag);
               x = $urandom_range(0, 1) || mag == 32768 ? 16'(-mag) : 16'(mag);
            end
            9: begin
               y = extremes[$urandom_range(0, 6)];
               x = extremes[$urandom_range(0, 6)];
            end
            default: begin
               y = 16'($urandom);
               x = 16'($urandom);
            end
         endcase
         send_vector(y, x, round_q13(vector_angle(y, x)));
      end

      // Drain and report
      drain_angles();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("atan2_series_angle_unit test passed");
      else
         $display("atan2_series_angle_unit test failed");
      $finish;
   end

endmodule
